/* sv/ntp_pkg.sv */
// ----------------------------------------------------------------------------
// Nearest target pursuit package
// Shared constants, command codes, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package ntp_pkg;

  localparam int MAX_TARGETS  = 32;
  localparam int CORDIC_STEPS = 14;
  localparam int SLOT_W       = $clog2(MAX_TARGETS);
  localparam int FILL_W       = $clog2(MAX_TARGETS + 1);
  localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

  localparam logic signed [19:0] PI_Q12 = 20'sd12868;
  localparam logic signed [31:0] PI_Q16 = 32'sd205887;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_HOME_X    = 3'd0,
    REG_HOME_Y    = 3'd1,
    REG_FAR       = 3'd2,
    REG_HEAD_TOL  = 3'd3,
    REG_CAPTURE   = 3'd4,
    REG_CREEP     = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_PICK_RD,
    ST_PICK,
    ST_YAW_PRE,
    ST_YAW,
    ST_BEAR_PRE,
    ST_BEAR,
    ST_SQRT,
    ST_DECIDE,
    ST_SCALE,
    ST_OUT
  } state_t;

  // CORDIC arc table in Q16.
  function automatic logic signed [31:0] atan_q16(input logic [4:0] i);
    unique case (i)
      5'd0:  atan_q16 = 32'sd51472;
      5'd1:  atan_q16 = 32'sd30385;
      5'd2:  atan_q16 = 32'sd16055;
      5'd3:  atan_q16 = 32'sd8150;
      5'd4:  atan_q16 = 32'sd4091;
      5'd5:  atan_q16 = 32'sd2047;
      5'd6:  atan_q16 = 32'sd1024;
      5'd7:  atan_q16 = 32'sd512;
      5'd8:  atan_q16 = 32'sd256;
      5'd9:  atan_q16 = 32'sd128;
      5'd10: atan_q16 = 32'sd64;
      5'd11: atan_q16 = 32'sd32;
      5'd12: atan_q16 = 32'sd16;
      5'd13: atan_q16 = 32'sd8;
      5'd14: atan_q16 = 32'sd4;
      5'd15: atan_q16 = 32'sd2;
      5'd16: atan_q16 = 32'sd1;
      5'd17: atan_q16 = 32'sd1;
      default: atan_q16 = 32'sd0;
    endcase
  endfunction

endpackage

/* sv/ntp_cordic.sv */
// ----------------------------------------------------------------------------
// Nearest target pursuit CORDIC unit
// Vectoring atan2, one micro-rotation per cycle, result rounded to Q3.12.
// ----------------------------------------------------------------------------
module ntp_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] y_in,
  input  logic signed [31:0] x_in,
  output logic               done,
  output logic signed [15:0] angle
);
  import ntp_pkg::*;

  logic signed [34:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [31:0] z_r, z_nxt;
  logic [STEP_W-1:0]  i_r, i_nxt;
  logic               busy_r, busy_nxt;
  logic signed [34:0] xs, ys;
  logic signed [31:0] zr;

  // Shifted copies; arithmetic shift matches floor division.
  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign zr = (z_r + 32'sd8) >>> 4;
  assign angle = zr[15:0];
  assign done = busy_r && (i_r == STEP_W'(CORDIC_STEPS));

  // Pre-rotation on start, then one step per cycle.
  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r; busy_nxt = busy_r;
    if (start) begin
      busy_nxt = 1'b1;
      i_nxt = '0;
      if (x_in < 0) begin
        x_nxt = -35'(x_in);
        y_nxt = -35'(y_in);
        z_nxt = (y_in >= 0) ? PI_Q16 : -PI_Q16;
      end else begin
        x_nxt = 35'(x_in);
        y_nxt = 35'(y_in);
        z_nxt = '0;
      end
      if (x_in == 0 && y_in == 0) z_nxt = '0;
    end else if (busy_r) begin
      if (i_r == STEP_W'(CORDIC_STEPS)) begin
        busy_nxt = 1'b0;
      end else begin
        if (y_r > 0) begin
          x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + atan_q16(5'(i_r));
        end else if (y_r < 0) begin
          x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - atan_q16(5'(i_r));
        end
        i_nxt = i_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      i_r <= i_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
  end

endmodule

/* sv/nearest_target_pursuit.sv */
// ----------------------------------------------------------------------------
// Nearest target pursuit controller
// Nearest-target scan, CORDIC yaw and bearing, square root and speed rules.
// ----------------------------------------------------------------------------
// Clear and load requests are completed without leaving the idle state. The
// block takes the next request in the cycle after a tick's result is taken,
// so a tick is held up by any output stall. The table scan reads the target
// memory once per slot, in the scan read and scan compare states, the shared
// CORDIC unit runs two atan2 passes, and the square root resolves one result
// bit per cycle. in_stall is high while a tick is in progress or its result
// waits on the output.
module nearest_target_pursuit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_linear_speed,
  output logic signed [15:0] out_angular_speed,
  output logic        out_heading_home,
  output logic [4:0]  out_target_slot,
  output logic        out_target_reached,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ntp_pkg::*;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic signed [15:0] home_x_r, home_y_r;
  logic [14:0] far_r, cap_r, creep_r;
  logic [13:0] tol_r;

  // Target table.
  logic signed [15:0] tx_mem [MAX_TARGETS];
  logic signed [15:0] ty_mem [MAX_TARGETS];
  logic [MAX_TARGETS-1:0] valid_r;
  logic [FILL_W-1:0] fill_r;
  logic loaded_r;
  logic signed [15:0] rdx_r, rdy_r;
  logic [SLOT_W-1:0] rd_addr;

  // Working registers.
  logic signed [15:0] px_r, py_r, qw_r, qx_r, qy_r, qz_r;
  logic [FILL_W-1:0] idx_r;
  logic [SLOT_W-1:0] best_slot_r;
  logic [32:0] best_r;
  logic found_r;
  logic signed [16:0] dx_r, dy_r;
  logic [32:0] d2_r;
  logic signed [31:0] m_r;
  logic [1:0] mstep_r;
  logic signed [31:0] sy_r, cy_r;
  logic signed [15:0] yaw_r, bear_r;
  logic [32:0] rem_r;
  logic [16:0] root_r;
  logic [4:0] sq_r;
  logic signed [19:0] err_r;
  logic far_q_r, turn_r;
  logic [14:0] lin_r;
  logic signed [15:0] ang_r;
  logic reached_r;

  logic accept, cord_start, cord_done;
  logic signed [15:0] cord_angle;
  logic signed [31:0] cord_y, cord_x;
  logic signed [16:0] sdx, sdy;
  logic [32:0] sd2;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE);
  assign rd_addr   = (state_r == ST_PICK_RD) ? best_slot_r : idx_r[SLOT_W-1:0];

  // Squared distance to the slot just read.
  assign sdx = 17'(rdx_r) - 17'(px_r);
  assign sdy = 17'(rdy_r) - 17'(py_r);
  assign sd2 = 33'(34'(sdx * sdx) + 34'(sdy * sdy));

  assign cord_y = (state_r == ST_YAW_PRE) ? sy_r : 32'(dy_r);
  assign cord_x = (state_r == ST_YAW_PRE) ? cy_r : 32'(dx_r);
  assign cord_start = (state_r == ST_YAW_PRE) || (state_r == ST_BEAR_PRE);

  ntp_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cord_start),
    .y_in(cord_y), .x_in(cord_x), .done(cord_done), .angle(cord_angle)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (accept && in_command == CMD_TICK && loaded_r) state_nxt = ST_SCAN_RD;
      ST_SCAN_RD:  state_nxt = (idx_r < fill_r) ? ST_SCAN_CMP : ST_PICK_RD;
      ST_SCAN_CMP: state_nxt = ST_SCAN_RD;
      ST_PICK_RD:  state_nxt = ST_PICK;
      ST_PICK:     state_nxt = (mstep_r == 2'd2) ? ST_YAW_PRE : ST_PICK;
      ST_YAW_PRE:  state_nxt = ST_YAW;
      ST_YAW:      if (cord_done) state_nxt = ST_BEAR_PRE;
      ST_BEAR_PRE: state_nxt = ST_BEAR;
      ST_BEAR:     if (cord_done) state_nxt = ST_SQRT;
      ST_SQRT:     if (sq_r == 5'd16) state_nxt = ST_DECIDE;
      ST_DECIDE:   state_nxt = ST_SCALE;
      ST_SCALE:    state_nxt = ST_OUT;
      ST_OUT:      if (!out_stall) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
  end

  assign out_linear_speed   = lin_r;
  assign out_angular_speed  = ang_r;
  assign out_heading_home   = !found_r;
  assign out_target_slot    = 5'(best_slot_r);
  assign out_target_reached = reached_r;

  // Target memory, one write and one registered read.
  always_ff @(posedge clk) begin
    if (accept && in_command == CMD_LOAD && fill_r < FILL_W'(MAX_TARGETS)) begin
      tx_mem[fill_r[SLOT_W-1:0]] <= in_pos_x;
      ty_mem[fill_r[SLOT_W-1:0]] <= in_pos_y;
    end
    rdx_r <= tx_mem[rd_addr];
    rdy_r <= ty_mem[rd_addr];
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      valid_r  <= '0;
      fill_r   <= '0;
      loaded_r <= 1'b0;
      home_x_r <= 16'sd11264;
      home_y_r <= 16'sd11264;
      far_r    <= 15'd5120;
      tol_r    <= 14'd410;
      cap_r    <= 15'd307;
      creep_r  <= 15'd307;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_HOME_X:   home_x_r <= cfg_data;
          REG_HOME_Y:   home_y_r <= cfg_data;
          REG_FAR:      far_r    <= cfg_data[14:0];
          REG_HEAD_TOL: tol_r    <= cfg_data[13:0];
          REG_CAPTURE:  cap_r    <= cfg_data[14:0];
          REG_CREEP:    creep_r  <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (accept && in_command == CMD_CLEAR) begin
        valid_r <= '0;
        fill_r  <= '0;
      end
      if (accept && in_command == CMD_LOAD) begin
        loaded_r <= 1'b1;
        if (fill_r < FILL_W'(MAX_TARGETS)) begin
          valid_r[fill_r[SLOT_W-1:0]] <= 1'b1;
          fill_r <= fill_r + 1'b1;
        end
      end
      if (state_r == ST_DECIDE && found_r && d2_r < 33'(cap_r * cap_r))
        valid_r[best_slot_r] <= 1'b0;
    end
  end

  // Datapath sequencing.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        px_r <= in_pos_x; py_r <= in_pos_y;
        qw_r <= in_quat_w; qx_r <= in_quat_x; qy_r <= in_quat_y; qz_r <= in_quat_z;
        idx_r <= '0; found_r <= 1'b0; best_slot_r <= '0; best_r <= '0;
        mstep_r <= '0;
      end
      ST_SCAN_RD: ;
      ST_SCAN_CMP: begin
        if (valid_r[idx_r[SLOT_W-1:0]] && (!found_r || sd2 < best_r)) begin
          best_r <= sd2; best_slot_r <= idx_r[SLOT_W-1:0]; found_r <= 1'b1;
        end
        idx_r <= idx_r + 1'b1;
      end
      ST_PICK_RD: ;
      ST_PICK: begin
        // The yaw terms are built up step by step, with m_r carrying a partial product.
        mstep_r <= mstep_r + 1'b1;
        unique case (mstep_r)
          2'd0: begin
            dx_r <= found_r ? sdx : 17'(home_x_r) - 17'(px_r);
            dy_r <= found_r ? sdy : 17'(home_y_r) - 17'(py_r);
            m_r  <= 32'(qw_r * qz_r);
          end
          2'd1: begin
            sy_r <= 32'(m_r + 32'(qx_r * qy_r)) <<< 1;
            m_r  <= 32'(qy_r * qy_r);
          end
          default: begin
            cy_r <= 32'sh1000_0000 - ((m_r + 32'(qz_r * qz_r)) <<< 1);
          end
        endcase
      end
      ST_YAW_PRE: ;
      ST_YAW: if (cord_done) yaw_r <= cord_angle;
      ST_BEAR_PRE: begin
        d2_r <= 33'(34'(dx_r * dx_r) + 34'(dy_r * dy_r));
        rem_r <= 33'(34'(dx_r * dx_r) + 34'(dy_r * dy_r));
        root_r <= '0; sq_r <= '0;
      end
      ST_BEAR: if (cord_done) bear_r <= cord_angle;
      ST_SQRT: begin
        // Restoring square root, one result bit per cycle.
        logic [33:0] trial;
        logic [32:0] top;
        top = 33'(rem_r >> (6'd32 - {sq_r, 1'b0}));
        trial = {root_r, 2'b01};
        if (sq_r == 5'd0) top = 33'(rem_r[32]);
        if (34'(top) >= trial) begin
          rem_r <= rem_r - 33'(trial << (6'd32 - {sq_r, 1'b0}));
          root_r <= {root_r[15:0], 1'b1};
        end else begin
          root_r <= {root_r[15:0], 1'b0};
        end
        sq_r <= sq_r + 1'b1;
        if (sq_r == 5'd0) begin
          err_r <= 20'(bear_r) - 20'(yaw_r);
        end else if (err_r > PI_Q12) begin
          err_r <= err_r - 20'(2 * PI_Q12);
        end else if (err_r < -PI_Q12) begin
          err_r <= err_r + 20'(2 * PI_Q12);
        end
      end
      ST_DECIDE: begin
        far_q_r <= d2_r > 33'(far_r * far_r);
        turn_r <= ((err_r < 0) ? -err_r : err_r) > 20'(tol_r);
        reached_r <= found_r && d2_r < 33'(cap_r * cap_r);
        m_r <= 32'((err_r < 0) ? -err_r : err_r);
      end
      ST_SCALE: begin
        // round(k*|e|/10), ties away from zero: (2*k*|e| + 10) / 20.
        logic [27:0] num, q;
        num = far_q_r ? 28'((m_r << 2) + 32'sd10) : 28'(m_r * 6 + 10);
        q = 28'((56'(num) * 56'd13421773) >> 28);
        if (28'(q * 20) > num) q = q - 1'b1;
        if (far_q_r) begin
          lin_r <= (root_r[16]) ? 15'h7FFF : 15'(root_r >> 1);
          ang_r <= turn_r ? ((err_r < 0) ? -16'(q) : 16'(q)) : '0;
        end else if (turn_r) begin
          lin_r <= '0;
          ang_r <= (err_r < 0) ? -16'(q) : 16'(q);
        end else begin
          lin_r <= creep_r;
          ang_r <= '0;
        end
      end
      ST_OUT: ;
      default: ;
    endcase
  end

endmodule

/* sv/ntp_checker.sv */
// ----------------------------------------------------------------------------
// Nearest target pursuit checker
// Port-level properties of the request, result and configuration channels.
// ----------------------------------------------------------------------------
module ntp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [14:0] out_linear_speed,
  input logic out_heading_home,
  input logic out_target_reached,
  input logic cfg_ready
);
  import ntp_pkg::*;

  // A held result keeps its linear speed.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_linear_speed))
    else $error("result changed while stalled");

  // No request is taken while a result is shown.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // Configuration is refused during a tick.
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !cfg_ready)
    else $error("config open while busy");

  // Heading home never reports a capture.
  a_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_heading_home |-> !out_target_reached)
    else $error("capture reported on home");

endmodule

bind nearest_target_pursuit ntp_checker u_ntp_checker (.*);
